// ===== design/thick_polyline_quad_expander_macros.svh =====
// Assertion macros used by tpq_back.
`ifndef THICK_POLYLINE_QUAD_EXPANDER_MACROS_SVH
`define THICK_POLYLINE_QUAD_EXPANDER_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define TPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define TPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

// ===== design/tpq_pkg.sv =====
// ----------------------------------------------------------------------------
// tpq_pkg
// Shared types and constants of the thick polyline quad expander.
// ----------------------------------------------------------------------------
package tpq_pkg;
	localparam int XW = 24;
	localparam int YW = 20;
	localparam int VW = 24;

	// Register indexes.
	localparam logic [2:0] REG_ITEM_WIDTH = 3'd0;
	localparam logic [2:0] REG_SIDE_PAD   = 3'd1;
	localparam logic [2:0] REG_MAX_SEG    = 3'd2;
	localparam logic [2:0] REG_LINE_WIDTH = 3'd3;
	localparam logic [2:0] REG_COLOR_RGB  = 3'd4;
	localparam logic [2:0] REG_COLOR_A    = 3'd5;
	localparam logic [2:0] REG_OPACITY    = 3'd6;

	// One segment handed from front to back.
	typedef struct packed {
		logic signed [XW-1:0] x1;
		logic signed [YW-1:0] y1;
		logic signed [XW-1:0] x2;
		logic signed [YW-1:0] y2;
	} seg_t;

	// Saturate a wide signed value to the vertex range.
	function automatic logic signed [VW-1:0] sat_v(input logic signed [27:0] v);
		logic signed [27:0] hi;
		logic signed [27:0] lo;
		hi = 28'sd8388607;
		lo = -28'sd8388608;
		if (v > hi) return 24'sh7FFFFF;
		else if (v < lo) return 24'sh800000;
		else return v[VW-1:0];
	endfunction
endpackage

// ===== design/thick_polyline_quad_expander.sv =====
// ----------------------------------------------------------------------------
// thick_polyline_quad_expander
// Turns a stream of polyline points into two triangles per segment.
// ----------------------------------------------------------------------------
// Usage:
//  s_axis carries one point per transaction; tuser holds first_point.
//  m_axis carries one vertex per transaction; tlast marks the sixth vertex.
//  Configuration is written through cfg_we/cfg_index/cfg_data while idle.
// Operation:
//  The front takes a new point only once it has mapped x through one
//  multiply and decided on the last one. The back handles one segment at a
//  time: it takes it, squares and sums the deltas, runs a square root, a
//  setup step and an offset divider, then alpha, red, green and blue color
//  steps, then six vertices, waiting on output stalls. A one-entry register
//  between front and back lets the front take the next point meanwhile.
// Reset clears trail state and loads register defaults (line width 1 px,
//  opacity 255). When m_axis_tready is low the vertex holds and the back
//  waits; once the queue is full the front stops taking points.
// ----------------------------------------------------------------------------
module thick_polyline_quad_expander import tpq_pkg::*; #(
	parameter int MAX_SEGMENT_LIMIT = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,   // x_ratio[17:0], y_pos[37:18], zero pad
	input  logic        s_axis_tuser,   // first_point
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [79:0] m_axis_tdata,   // vertex_x, vertex_y, red, green, blue, alpha
	output logic        m_axis_tlast
);
	logic [12:0] item_width_q;
	logic [11:0] side_padding_q;
	logic [12:0] max_segments_q;
	logic [7:0]  line_width_q;
	logic [23:0] color_rgb_q;
	logic [7:0]  color_alpha_q;
	logic [7:0]  opacity_q;

	logic seg_valid, seg_ready;
	seg_t seg;
	logic [VW-1:0] vx, vy;
	logic [7:0] vr, vg, vb, va;

	// Write configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_width_q <= '0;
			side_padding_q <= '0;
			max_segments_q <= '0;
			line_width_q <= 8'd16;
			color_rgb_q <= '0;
			color_alpha_q <= '0;
			opacity_q <= 8'd255;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ITEM_WIDTH: item_width_q <= cfg_data[12:0];
				REG_SIDE_PAD:   side_padding_q <= cfg_data[11:0];
				REG_MAX_SEG:    max_segments_q <= cfg_data[12:0];
				REG_LINE_WIDTH: line_width_q <= cfg_data[7:0];
				REG_COLOR_RGB:  color_rgb_q <= cfg_data;
				REG_COLOR_A:    color_alpha_q <= cfg_data[7:0];
				REG_OPACITY:    opacity_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	tpq_front #(.MAX_SEGMENT_LIMIT(MAX_SEGMENT_LIMIT)) u_front (
		.clk, .arst_n,
		.item_width(item_width_q), .side_padding(side_padding_q),
		.max_segments(max_segments_q),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.first_point(s_axis_tuser),
		.x_ratio($signed(s_axis_tdata[17:0])), .y_pos($signed(s_axis_tdata[37:18])),
		.seg_valid, .seg_ready, .seg
	);

	tpq_back u_back (
		.clk, .arst_n,
		.line_width(line_width_q), .color_rgb(color_rgb_q),
		.color_alpha(color_alpha_q), .opacity(opacity_q),
		.seg_valid, .seg_ready, .seg,
		.vo_valid(m_axis_tvalid), .vo_ready(m_axis_tready),
		.vo_x(vx), .vo_y(vy), .vo_r(vr), .vo_g(vg), .vo_b(vb), .vo_a(va),
		.vo_last(m_axis_tlast)
	);

	assign m_axis_tdata = {va, vb, vg, vr, vy, vx};
endmodule

// ===== design/tpq_front.sv =====
// ----------------------------------------------------------------------------
// tpq_front
// Accepts points, maps x, tracks the trail and queues segments to draw.
// ----------------------------------------------------------------------------
module tpq_front import tpq_pkg::*; #(
	parameter int MAX_SEGMENT_LIMIT = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [12:0]        item_width,
	input  logic [11:0]        side_padding,
	input  logic [12:0]        max_segments,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               first_point,
	input  logic signed [17:0] x_ratio,
	input  logic signed [19:0] y_pos,
	output logic               seg_valid,
	input  logic               seg_ready,
	output seg_t               seg
);
	localparam int CW = $clog2(MAX_SEGMENT_LIMIT + 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DEC  = 2'd2;

	logic [1:0]        state_q;
	logic              first_q;
	logic [16:0]       ratio_q;
	logic signed [YW-1:0] y_q;
	logic [13:0]       usable_q;
	logic [34:0]       prod_q;
	logic signed [XW-1:0] prev_x_q;
	logic signed [YW-1:0] prev_y_q;
	logic              have_prev_q;
	logic [CW-1:0]     count_q;
	logic              out_valid_q;
	seg_t              out_q;

	logic signed [14:0] usable_w;
	logic [CW-1:0]      limit_w;
	logic signed [XW-1:0] x2_w;
	logic               dec_fire_w;

	// Usable width, segment limit, mapped x and the decide condition.
	always_comb begin
		usable_w = $signed({2'b0, (item_width == '0) ? 13'd1 : item_width})
			- $signed({2'b0, side_padding, 1'b0});
		if (usable_w < 15'sd1) usable_w = 15'sd1;
		if ({19'd0, max_segments} > 32'(MAX_SEGMENT_LIMIT))
			limit_w = CW'(MAX_SEGMENT_LIMIT);
		else
			limit_w = CW'(max_segments);
		x2_w = $signed({8'd0, side_padding, 4'd0})
			+ $signed({4'd0, 20'((prod_q + 35'd32768) >> 16)});
		dec_fire_w = (state_q == ST_DEC) && (!out_valid_q || seg_ready)
			&& !first_q && have_prev_q && (count_q < limit_w);
	end

	assign in_ready = (state_q == ST_IDLE);
	assign seg_valid = out_valid_q;
	assign seg = out_q;

	// Sequence one point: capture, multiply, decide.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			have_prev_q <= 1'b0;
			count_q <= '0;
			prev_x_q <= '0;
			prev_y_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= dec_fire_w || (out_valid_q && !seg_ready);
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						first_q <= first_point;
						ratio_q <= x_ratio[17] ? 17'd0 :
							(x_ratio > 18'sd65536 ? 17'd65536 : x_ratio[16:0]);
						y_q <= y_pos;
						usable_q <= usable_w[13:0];
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					prod_q <= 35'(ratio_q) * 35'({usable_q, 4'd0});
					state_q <= ST_DEC;
				end
				ST_DEC: begin
					if (!out_valid_q || seg_ready) begin
						prev_x_q <= x2_w;
						prev_y_q <= y_q;
						if (first_q || !have_prev_q) begin
							count_q <= '0;
							have_prev_q <= 1'b1;
						end else if (count_q < limit_w) begin
							count_q <= count_q + 1'b1;
							out_q <= '{x1: prev_x_q, y1: prev_y_q, x2: x2_w, y2: y_q};
						end
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// ===== design/tpq_back.sv =====
// ----------------------------------------------------------------------------
// tpq_back
// Computes normal offset and color for one segment and emits six vertices; drops segments shorter than half a pixel.
// ----------------------------------------------------------------------------
`include "thick_polyline_quad_expander_macros.svh"
module tpq_back import tpq_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic [7:0]   line_width,
	input  logic [23:0]  color_rgb,
	input  logic [7:0]   color_alpha,
	input  logic [7:0]   opacity,
	input  logic         seg_valid,
	output logic         seg_ready,
	input  seg_t         seg,
	output logic         vo_valid,
	input  logic         vo_ready,
	output logic [VW-1:0] vo_x,
	output logic [VW-1:0] vo_y,
	output logic [7:0]   vo_r,
	output logic [7:0]   vo_g,
	output logic [7:0]   vo_b,
	output logic [7:0]   vo_a,
	output logic         vo_last
);
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SQ   = 4'd1;
	localparam logic [3:0] ST_SUM  = 4'd2;
	localparam logic [3:0] ST_SQRT = 4'd3;
	localparam logic [3:0] ST_NUM  = 4'd4;
	localparam logic [3:0] ST_DIV  = 4'd5;
	localparam logic [3:0] ST_COL  = 4'd6;
	localparam logic [3:0] ST_EMIT = 4'd7;

	logic [3:0]  state_q;
	seg_t        seg_q;
	logic signed [25:0] dx_q, dy_q;
	logic [51:0] sqx_q, sqy_q;
	logic [68:0] rem_q;
	logic [34:0] root_q;
	logic [5:0]  step_q;
	logic [47:0] qx_q, qy_q;
	logic [47:0] rx_q, ry_q;
	logic [40:0] den_q;
	logic [15:0] amul_q;
	logic [7:0]  a_q, r_q, g_q, b_q;
	logic [1:0]  cstep_q;
	logic signed [25:0] ox_q, oy_q;
	logic [2:0]  k_q;

	logic [70:0] trial_w;
	logic [48:0] rxs_w, rys_w;
	logic [7:0]  hw_w;
	logic [15:0] cmul_w;
	logic [7:0]  cdiv_w;
	logic signed [27:0] vx_w, vy_w;

	assign hw_w = (line_width < 8'd8) ? 8'd8 : line_width;

	// One root digit per cycle: n is d2 << 16, two bits per step.
	assign trial_w = {rem_q[66:0], sqx_q[51:50]} - {root_q, 2'b01};
	// One quotient bit per cycle for both offsets.
	assign rxs_w = {rx_q, qx_q[47]};
	assign rys_w = {ry_q, qy_q[47]};

	// Color divide by 255 with rounding (value below 65152).
	always_comb begin
		cmul_w = amul_q + 16'd127;
		cdiv_w = 8'((32'(cmul_w) * 32'd257 + 32'd257) >> 16);
	end

	// Select vertex: A,B,C,C,B,D.
	always_comb begin
		logic use2, neg;
		use2 = (k_q == 3'd2) || (k_q == 3'd3) || (k_q == 3'd5);
		neg  = (k_q == 3'd1) || (k_q == 3'd4) || (k_q == 3'd5);
		vx_w = 28'(use2 ? seg_q.x2 : seg_q.x1) + (neg ? -28'(ox_q) : 28'(ox_q));
		vy_w = 28'(use2 ? seg_q.y2 : seg_q.y1) + (neg ? -28'(oy_q) : 28'(oy_q));
	end

	assign seg_ready = (state_q == ST_IDLE);
	assign vo_valid = (state_q == ST_EMIT);
	assign vo_x = sat_v(vx_w);
	assign vo_y = sat_v(vy_w);
	assign vo_r = r_q;
	assign vo_g = g_q;
	assign vo_b = b_q;
	assign vo_a = a_q;
	assign vo_last = (k_q == 3'd5);

	// Segment sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (seg_valid) begin
						seg_q <= seg;
						dx_q <= 26'(seg.x2) - 26'(seg.x1);
						dy_q <= 26'(seg.y2) - 26'(seg.y1);
						state_q <= ST_SQ;
					end
				end
				ST_SQ: begin
					sqx_q <= 52'($unsigned(dx_q < 0 ? -dx_q : dx_q))
						* 52'($unsigned(dx_q < 0 ? -dx_q : dx_q));
					sqy_q <= 52'($unsigned(dy_q < 0 ? -dy_q : dy_q))
						* 52'($unsigned(dy_q < 0 ? -dy_q : dy_q));
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					// Drop segments shorter than half a pixel.
					if ((sqx_q + sqy_q) < 52'd64) begin
						state_q <= ST_IDLE;
					end else begin
						sqx_q <= sqx_q + sqy_q;
						rem_q <= '0;
						root_q <= '0;
						step_q <= '0;
						state_q <= ST_SQRT;
					end
				end
				ST_SQRT: begin
					// n = d2 << 16: 26 data digits then 8 zero digits.
					if (!trial_w[70]) begin
						rem_q <= trial_w[68:0];
						root_q <= {root_q[33:0], 1'b1};
					end else begin
						rem_q <= {rem_q[66:0], sqx_q[51:50]};
						root_q <= {root_q[33:0], 1'b0};
					end
					sqx_q <= {sqx_q[49:0], 2'b00};
					step_q <= step_q + 6'd1;
					if (step_q == 6'd33) state_q <= ST_NUM;
				end
				ST_NUM: begin
					den_q <= {1'b0, root_q, 5'd0};
					qx_q <= 48'({36'($unsigned(dy_q < 0 ? -dy_q : dy_q)) * 36'(hw_w), 12'd0})
						+ 48'({root_q, 4'd0});
					qy_q <= 48'({36'($unsigned(dx_q < 0 ? -dx_q : dx_q)) * 36'(hw_w), 12'd0})
						+ 48'({root_q, 4'd0});
					rx_q <= '0;
					ry_q <= '0;
					step_q <= '0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (rxs_w >= 49'(den_q)) begin
						rx_q <= 48'(rxs_w - 49'(den_q));
						qx_q <= {qx_q[46:0], 1'b1};
					end else begin
						rx_q <= rxs_w[47:0];
						qx_q <= {qx_q[46:0], 1'b0};
					end
					if (rys_w >= 49'(den_q)) begin
						ry_q <= 48'(rys_w - 49'(den_q));
						qy_q <= {qy_q[46:0], 1'b1};
					end else begin
						ry_q <= rys_w[47:0];
						qy_q <= {qy_q[46:0], 1'b0};
					end
					step_q <= step_q + 6'd1;
					if (step_q == 6'd47) begin
						cstep_q <= 2'd3;
						amul_q <= 16'(color_alpha) * 16'(opacity);
						state_q <= ST_COL;
					end
				end
				ST_COL: begin
					// ox = -sign(dy)*qx, oy = sign(dx)*qy.
					ox_q <= dy_q < 0 ? 26'(qx_q) : -26'(qx_q);
					oy_q <= dx_q < 0 ? -26'(qy_q) : 26'(qy_q);
					unique case (cstep_q)
						2'd3: begin
							a_q <= cdiv_w;
							amul_q <= 16'(color_rgb[23:16]) * 16'(cdiv_w);
							cstep_q <= 2'd0;
						end
						2'd0: begin
							r_q <= cdiv_w;
							amul_q <= 16'(color_rgb[15:8]) * 16'(a_q);
							cstep_q <= 2'd1;
						end
						2'd1: begin
							g_q <= cdiv_w;
							amul_q <= 16'(color_rgb[7:0]) * 16'(a_q);
							cstep_q <= 2'd2;
						end
						default: begin
							b_q <= cdiv_w;
							k_q <= '0;
							state_q <= ST_EMIT;
						end
					endcase
				end
				ST_EMIT: begin
					if (vo_ready) begin
						if (k_q == 3'd5) state_q <= ST_IDLE;
						k_q <= k_q + 3'd1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	`TPQ_ASSERT_IMP(a_ready_idle, clk, arst_n, seg_ready, !vo_valid, "segment taken while emitting")
	`TPQ_ASSERT_NEXT(a_last_ends, clk, arst_n, vo_valid && vo_ready && vo_last, !vo_valid, "vertex after last")
	`TPQ_ASSERT_IMP(a_k_range, clk, arst_n, vo_valid, k_q < 3'd6, "vertex index out of range")
endmodule

// ===== verif/thick_polyline_quad_expander_tb.sv =====
// ----------------------------------------------------------------------------
// thick_polyline_quad_expander_tb
// Streams polyline points into the expander and checks every vertex it emits
// against a cycle-free predictor of the segment widening, under several
// register settings and input/output idling patterns.
// ----------------------------------------------------------------------------
module thick_polyline_quad_expander_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import tpq_pkg::*;

	localparam int SEG_CAP      = 4096;
	localparam int SETTLE_CYC   = 200;
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASES       = 6;
	localparam int PTS_PER_PHASE = 70;

	typedef struct {
		logic [23:0] vx;
		logic [23:0] vy;
		logic [7:0]  r;
		logic [7:0]  g;
		logic [7:0]  b;
		logic [7:0]  a;
		logic        last;
	} vertex_t;

	// Predicts vertices from accepted points and checks the emitted stream.
	class quad_scoreboard;
		longint unsigned area_w, pad, seg_max, stroke, rgb, base_a, opac;
		longint          last_x, last_y, seg_cnt;
		bit              in_trail;
		vertex_t         vertex_q[$];
		int              errors, points, vertices, segments;

		function void reset_state();
			area_w = 0; pad = 0; seg_max = 0; stroke = 16;
			rgb = 0; base_a = 0; opac = 255;
			last_x = 0; last_y = 0; seg_cnt = 0; in_trail = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [23:0] val);
			case (idx)
				REG_ITEM_WIDTH: area_w = val[12:0];
				REG_SIDE_PAD:   pad = val[11:0];
				REG_MAX_SEG:    seg_max = val[12:0];
				REG_LINE_WIDTH: stroke = val[7:0];
				REG_COLOR_RGB:  rgb = val;
				REG_COLOR_A:    base_a = val[7:0];
				REG_OPACITY:    opac = val[7:0];
				default: ;
			endcase
		endfunction

		function longint map_ratio(longint ratio);
			longint r, w, usable;
			r = ratio < 0 ? 0 : (ratio > 65536 ? 65536 : ratio);
			w = area_w != 0 ? area_w : 1;
			usable = w - 2 * longint'(pad);
			if (usable < 1) usable = 1;
			return (longint'(pad) << 4) + ((r * (usable << 4) + 32768) >>> 16);
		endfunction

		function longint unsigned root(longint unsigned n);
			longint unsigned res, bt;
			res = 0;
			bt = 64'd1 << 62;
			while (bt > n) bt >>= 2;
			while (bt != 0) begin
				if (n >= res + bt) begin
					n -= res + bt;
					res = (res >> 1) + bt;
				end else begin
					res >>= 1;
				end
				bt >>= 2;
			end
			return res;
		endfunction

		function longint offset(longint d, longint unsigned len);
			longint unsigned hw, mag, q;
			hw = stroke < 8 ? 8 : stroke;
			mag = (d < 0 ? -d : d) * hw;
			mag = mag << 12;
			q = (mag + 16 * len) / (32 * len);
			return d < 0 ? -longint'(q) : longint'(q);
		endfunction

		function logic [23:0] clip(longint v);
			if (v > 8388607) return 24'h7FFFFF;
			if (v < -8388608) return 24'h800000;
			return v[23:0];
		endfunction

		function void note_point(bit first, logic signed [17:0] ratio,
				logic signed [19:0] ypos);
			longint x2, y2, x1, y1, dx, dy, ox, oy, lim;
			longint unsigned d2, len, al, cr, cg, cb;
			longint vxs[6], vys[6];
			bit make;
			vertex_t v;
			points++;
			x2 = map_ratio(longint'(ratio));
			y2 = longint'(ypos);
			x1 = last_x;
			y1 = last_y;
			lim = seg_max > SEG_CAP ? SEG_CAP : seg_max;
			make = 0;
			if (first || !in_trail) begin
				seg_cnt = 0;
				in_trail = 1;
			end else if (seg_cnt < lim) begin
				seg_cnt++;
				make = 1;
			end
			last_x = x2;
			last_y = y2;
			if (!make) return;
			dx = x2 - x1;
			dy = y2 - y1;
			d2 = dx * dx + dy * dy;
			// drop segments shorter than half a pixel
			if (d2 < 64) return;
			segments++;
			len = root(d2 << 16);
			ox = -offset(dy, len);
			oy = offset(dx, len);
			al = (base_a * opac + 127) / 255;
			cr = (((rgb >> 16) & 8'hFF) * al + 127) / 255;
			cg = (((rgb >> 8) & 8'hFF) * al + 127) / 255;
			cb = ((rgb & 8'hFF) * al + 127) / 255;
			vxs = '{x1 + ox, x1 - ox, x2 + ox, x2 + ox, x1 - ox, x2 - ox};
			vys = '{y1 + oy, y1 - oy, y2 + oy, y2 + oy, y1 - oy, y2 - oy};
			for (int k = 0; k < 6; k++) begin
				v.vx = clip(vxs[k]);
				v.vy = clip(vys[k]);
				v.r = 8'(cr);
				v.g = 8'(cg);
				v.b = 8'(cb);
				v.a = 8'(al);
				v.last = (k == 5);
				vertex_q.push_back(v);
			end
		endfunction

		function void check_vertex(logic [79:0] data, logic last);
			vertex_t e;
			vertices++;
			if (vertex_q.size() == 0) begin
				$error("unexpected vertex %h", data);
				errors++;
				return;
			end
			e = vertex_q.pop_front();
			if (data[23:0] !== e.vx) begin
				$error("vertex_x exp %h got %h", e.vx, data[23:0]); errors++;
			end
			if (data[47:24] !== e.vy) begin
				$error("vertex_y exp %h got %h", e.vy, data[47:24]); errors++;
			end
			if (data[55:48] !== e.r) begin
				$error("red exp %h got %h", e.r, data[55:48]); errors++;
			end
			if (data[63:56] !== e.g) begin
				$error("green exp %h got %h", e.g, data[63:56]); errors++;
			end
			if (data[71:64] !== e.b) begin
				$error("blue exp %h got %h", e.b, data[71:64]); errors++;
			end
			if (data[79:72] !== e.a) begin
				$error("alpha exp %h got %h", e.a, data[79:72]); errors++;
			end
			if (last !== e.last) begin
				$error("last_vertex exp %b got %b", e.last, last); errors++;
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [2:0]  cfg_index;
	logic [23:0] cfg_data;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata;   // x_ratio[17:0], y_pos[37:18], zero pad
	logic        s_axis_tuser;   // first_point
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [79:0] m_axis_tdata;   // vertex_x, vertex_y, red, green, blue, alpha
	logic        m_axis_tlast;

	quad_scoreboard sb;
	int send_idle_pct;
	int recv_stall_pct;
	int quiet_cycles;
	logic signed [17:0] prev_ratio;
	logic signed [19:0] prev_ypos;

	thick_polyline_quad_expander dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
	);

	// Generate the clock.
	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// Check output transactions and randomize the receiver stall.
	always @(posedge clk) begin
		if (m_axis_tvalid && m_axis_tready)
			sb.check_vertex(m_axis_tdata, m_axis_tlast);
		m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
	end

	// End the run when no transaction moves for too long.
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("thick_polyline_quad_expander: mismatch");
			$finish;
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [23:0] val);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 0;
		sb.write_reg(idx, val);
	endtask

	task automatic send_point(bit first, logic signed [17:0] ratio,
			logic signed [19:0] ypos);
		// idle for a random number of cycles first
		while ($urandom_range(0, 99) < send_idle_pct) begin
			s_axis_tvalid <= 0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tuser <= first;
		s_axis_tdata <= {2'b0, ypos, ratio};
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		sb.note_point(first, ratio, ypos);
		prev_ratio = ratio;
		prev_ypos = ypos;
	endtask

	// Wait out every expected vertex plus the back end's latency.
	task automatic drain();
		s_axis_tvalid <= 0;
		@(posedge clk);
		while (sb.vertex_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYC) @(posedge clk);
	endtask

	task automatic load_setting(int ph);
		case (ph)
			0: begin
				write_reg(REG_ITEM_WIDTH, 640); write_reg(REG_SIDE_PAD, 10);
				write_reg(REG_MAX_SEG, 4096); write_reg(REG_LINE_WIDTH, 16);
				write_reg(REG_COLOR_RGB, 24'hFF8001); write_reg(REG_COLOR_A, 255);
				write_reg(REG_OPACITY, 255);
			end
			1: begin
				write_reg(REG_ITEM_WIDTH, 8191); write_reg(REG_SIDE_PAD, 0);
				write_reg(REG_MAX_SEG, 8191); write_reg(REG_LINE_WIDTH, 128);
				write_reg(REG_COLOR_RGB, 24'hFFFFFF); write_reg(REG_COLOR_A, 200);
				write_reg(REG_OPACITY, 100);
			end
			2: begin
				write_reg(REG_ITEM_WIDTH, 0); write_reg(REG_SIDE_PAD, 4095);
				write_reg(REG_MAX_SEG, 3); write_reg(REG_LINE_WIDTH, 2);
				write_reg(REG_COLOR_RGB, 24'h000000); write_reg(REG_COLOR_A, 0);
				write_reg(REG_OPACITY, 0);
			end
			3: begin
				write_reg(REG_ITEM_WIDTH, 300); write_reg(REG_SIDE_PAD, 200);
				write_reg(REG_MAX_SEG, 0); write_reg(REG_LINE_WIDTH, 7);
				write_reg(REG_COLOR_RGB, 24'h123456); write_reg(REG_COLOR_A, 1);
				write_reg(REG_OPACITY, 254);
			end
			4: begin
				write_reg(REG_ITEM_WIDTH, 1920); write_reg(REG_SIDE_PAD, 4);
				write_reg(REG_MAX_SEG, 12); write_reg(REG_LINE_WIDTH, 8);
				write_reg(REG_COLOR_RGB, 24'($urandom));
				write_reg(REG_COLOR_A, 24'($urandom_range(0, 255)));
				write_reg(REG_OPACITY, 24'($urandom_range(0, 255)));
			end
			default: begin
				write_reg(REG_ITEM_WIDTH, 24'($urandom_range(1, 4000)));
				write_reg(REG_SIDE_PAD, 24'($urandom_range(0, 300)));
				write_reg(REG_MAX_SEG, 24'($urandom_range(1, 4096)));
				write_reg(REG_LINE_WIDTH, 24'($urandom_range(2, 128)));
				write_reg(REG_COLOR_RGB, 24'($urandom));
				write_reg(REG_COLOR_A, 24'($urandom_range(0, 255)));
				write_reg(REG_OPACITY, 24'($urandom_range(0, 255)));
			end
		endcase
	endtask

	task automatic random_point(bit start);
		logic signed [17:0] ratio;
		logic signed [19:0] ypos;
		int roll;
		bit first;
		roll = $urandom_range(0, 99);
		first = start;
		// noise: stray trail starts and fully random fields
		if ($urandom_range(0, 99) < 5) first = 1'($urandom_range(0, 1));
		if (roll < 6) begin
			ratio = prev_ratio;
			ypos = prev_ypos;
		end else if (roll < 20) begin
			ratio = 18'($urandom);
			ypos = 20'($urandom);
		end else begin
			ratio = 18'($urandom_range(0, 65536));
			ypos = $signed(20'($urandom_range(0, 16000))) - 20'sd8000;
		end
		send_point(first, ratio, ypos);
	endtask

	initial begin
		sb = new();
		sb.reset_state();
		arst_n = 0;
		cfg_we = 0;
		cfg_index = REG_ITEM_WIDTH;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = 0;
		s_axis_tuser = 0;
		m_axis_tready = 0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		quiet_cycles = 0;
		prev_ratio = 0;
		prev_ypos = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: a point with no trail held, under reset registers.
		send_point(0, 18'sd1000, 20'sd100);
		send_point(0, 18'sd30000, 20'sd900);
		drain();
		load_setting(0);
		// ratio and position extremes, a degenerate segment, a fresh trail
		send_point(1, -18'sd131072, -20'sd524288);
		send_point(0, 18'sd131071, 20'sd524287);
		send_point(0, 18'sd0, 20'sd0);
		send_point(0, 18'sd65536, 20'sd0);
		send_point(0, 18'sd65536, 20'sd0);
		send_point(0, 18'sd65536, 20'sd4);
		send_point(1, 18'sd32768, -20'sd16);
		send_point(0, 18'sd32768, 20'sd16);
		drain();
		// thin stroke and the segment limit, trail carried across the change
		load_setting(2);
		for (int i = 0; i < 6; i++)
			send_point(i == 0, 18'(i * 13000), 20'(i * 50));
		drain();
		load_setting(3);
		send_point(0, 18'sd20000, 20'sd300);
		send_point(0, 18'sd40000, 20'sd10);
		drain();

		// Random trails under each setting and idling pattern.
		for (int ph = 0; ph < PHASES; ph++) begin
			int sent;
			load_setting(ph);
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			sent = 0;
			while (sent < PTS_PER_PHASE) begin
				int trail_len;
				trail_len = $urandom_range(2, 20);
				for (int k = 0; k < trail_len && sent < PTS_PER_PHASE; k++) begin
					random_point(k == 0);
					sent++;
				end
			end
			drain();
		end

		$display("Covered %0d points, %0d drawn segments, %0d vertices checked",
			sb.points, sb.segments, sb.vertices);
		$display("over %0d register settings with sender and receiver idling.", PHASES);
		if (sb.errors == 0 && sb.vertex_q.size() == 0) begin
			$display("thick_polyline_quad_expander: match");
		end else begin
			$display("thick_polyline_quad_expander: mismatch");
		end
		$finish;
	end
endmodule
